FILE: rtl/tfn_pkg.sv
// Package for the triangle face normal block: widths, pipeline depths and
// the side-band struct that travels with each item. No dependencies.
package tfn_pkg;

    localparam int COORD_W  = 16;   // Q8.8 vertex coordinate
    localparam int EDGE_W   = 17;   // edge vector component
    localparam int PROD_W   = 34;   // product of a u and a v edge component
    localparam int CROSS_W  = 35;   // cross product component, signed
    localparam int MAG_W    = 34;   // magnitude of a cross component
    localparam int SQ_W     = 68;   // squared magnitude and squared length
    localparam int NORM_W   = 16;   // Q2.14 normal component

    localparam int DIV_STEPS  = 31; // quotient bits of w_i^2 * 2^30 / |w|^2
    localparam int QUO_W      = 31;
    localparam int SQRT_STEPS = 16; // root bits of the quotient
    localparam int RAD_W      = 32;
    localparam int ROOT_W     = 16;
    localparam int SREM_W     = 17;

    localparam int FRONT_STAGES = 5;  // edges, products, cross, squares, length
    localparam int LANE_STAGES  = DIV_STEPS + SQRT_STEPS;
    localparam int NUM_STAGES   = FRONT_STAGES + LANE_STAGES + 1;

    typedef struct packed {
        logic [2:0] neg;   // sign of each cross component
        logic       zero;  // squared length is zero
    } tfn_side_t;

endpackage

FILE: rtl/tfn_if.sv
// Valid/ready channel interfaces for triangles in and normals out.
// Depends on tfn_pkg for field widths.
interface tfn_tri_if;
    logic                             valid;
    logic                             ready;
    logic signed [tfn_pkg::COORD_W-1:0] a_x, a_y, a_z;
    logic signed [tfn_pkg::COORD_W-1:0] b_x, b_y, b_z;
    logic signed [tfn_pkg::COORD_W-1:0] c_x, c_y, c_z;
    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    input ready);
    modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    output ready);
endinterface

interface tfn_norm_if;
    logic                              valid;
    logic                              ready;
    logic signed [tfn_pkg::NORM_W-1:0] normal_x, normal_y, normal_z;
    logic                              normal_valid;
    modport source (output valid, normal_x, normal_y, normal_z, normal_valid,
                    input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, normal_valid,
                    output ready);
endinterface

FILE: rtl/tfn_norm_lane.sv
// One normal component: restoring division of w_i^2 * 2^30 by |w|^2, one
// quotient bit per stage, then a digit-by-digit square root. Uses tfn_pkg.
module tfn_norm_lane
(
    input  logic                              clk,
    input  logic [tfn_pkg::LANE_STAGES-1:0]   en,
    input  logic [tfn_pkg::SQ_W-1:0]          w2,
    input  logic [tfn_pkg::SQ_W-1:0]          l2,
    output logic [tfn_pkg::ROOT_W-1:0]        root
);

    logic [tfn_pkg::SQ_W-1:0]   rem_reg  [tfn_pkg::DIV_STEPS];
    logic [tfn_pkg::SQ_W-1:0]   dsr_reg  [tfn_pkg::DIV_STEPS];
    logic [tfn_pkg::QUO_W-1:0]  quo_reg  [tfn_pkg::DIV_STEPS];

    logic [tfn_pkg::SREM_W-1:0] srem_reg [tfn_pkg::SQRT_STEPS];
    logic [tfn_pkg::ROOT_W-1:0] root_reg [tfn_pkg::SQRT_STEPS];
    logic [tfn_pkg::RAD_W-1:0]  rad_reg  [tfn_pkg::SQRT_STEPS];

    genvar i;
    generate
        for (i = 0; i < tfn_pkg::DIV_STEPS; i++)
        begin : g_div
            logic [tfn_pkg::SQ_W:0]     x;
            logic [tfn_pkg::SQ_W-1:0]   dsr_in;
            logic [tfn_pkg::QUO_W-1:0]  quo_in;
            logic [tfn_pkg::SQ_W:0]     diff;
            logic                       ge;
            if (i == 0)
            begin : g_first
                assign x      = {1'b0, w2};
                assign dsr_in = l2;
                assign quo_in = '0;
            end
            else
            begin : g_next
                assign x      = {rem_reg[i-1], 1'b0};
                assign dsr_in = dsr_reg[i-1];
                assign quo_in = quo_reg[i-1];
            end
            assign diff = x - {1'b0, dsr_in};
            assign ge   = (x >= {1'b0, dsr_in});

            always_ff @(posedge clk)
            begin
                if (en[i])
                begin
                    rem_reg[i] <= ge ? diff[tfn_pkg::SQ_W-1:0] : x[tfn_pkg::SQ_W-1:0];
                    dsr_reg[i] <= dsr_in;
                    quo_reg[i] <= {quo_in[tfn_pkg::QUO_W-2:0], ge};
                end
            end
        end

        for (i = 0; i < tfn_pkg::SQRT_STEPS; i++)
        begin : g_sqrt
            logic [tfn_pkg::SREM_W-1:0] srem_in;
            logic [tfn_pkg::ROOT_W-1:0] root_in;
            logic [tfn_pkg::RAD_W-1:0]  rad_in;
            logic [tfn_pkg::SREM_W:0]   x;
            logic [tfn_pkg::SREM_W:0]   trial;
            logic [tfn_pkg::SREM_W:0]   diff;
            logic                       ge;
            if (i == 0)
            begin : g_first
                assign srem_in = '0;
                assign root_in = '0;
                assign rad_in  = {1'b0, quo_reg[tfn_pkg::DIV_STEPS-1]};
            end
            else
            begin : g_next
                assign srem_in = srem_reg[i-1];
                assign root_in = root_reg[i-1];
                assign rad_in  = rad_reg[i-1];
            end
            // bring down two radicand bits, try appending a one to the root
            assign x     = {srem_in[tfn_pkg::SREM_W-2:0],
                            rad_in[tfn_pkg::RAD_W-1:tfn_pkg::RAD_W-2]};
            assign trial = {root_in, 2'b01};
            assign ge    = (x >= trial);
            assign diff  = x - trial;

            always_ff @(posedge clk)
            begin
                if (en[tfn_pkg::DIV_STEPS + i])
                begin
                    srem_reg[i] <= ge ? diff[tfn_pkg::SREM_W-1:0]
                                      : x[tfn_pkg::SREM_W-1:0];
                    root_reg[i] <= {root_in[tfn_pkg::ROOT_W-2:0], ge};
                    rad_reg[i]  <= {rad_in[tfn_pkg::RAD_W-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign root = root_reg[tfn_pkg::SQRT_STEPS-1];

endmodule

FILE: rtl/triangle_face_normal.sv
// Triangle unit face normal, fully pipelined: 53 register stages, one triangle per
// cycle sustained while nrm_out.ready is high; every stage can stall on its own,
// so bubbles close up while the result waits.
// The depth comes from the 31-step division and 16-step square root lanes.
// rst_n (async, active low) clears all stage valid bits; data regs hold.
// Depends on tfn_pkg, tfn_if and tfn_norm_lane.
module triangle_face_normal
(
    input  logic        clk,
    input  logic        rst_n,
    tfn_tri_if.sink     tri_in,
    tfn_norm_if.source  nrm_out
);

    localparam int NS = tfn_pkg::NUM_STAGES;
    localparam int FS = tfn_pkg::FRONT_STAGES;
    localparam int LS = tfn_pkg::LANE_STAGES;

    // Per-stage valid and advance. A stage loads when it is empty or the
    // stage after it is loading.
    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || nrm_out.ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign tri_in.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= tri_in.valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Stage 0: edge vectors u = b - a, v = c - a.
    logic signed [tfn_pkg::EDGE_W-1:0] ux_reg, uy_reg, uz_reg;
    logic signed [tfn_pkg::EDGE_W-1:0] vx_reg, vy_reg, vz_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ux_reg <= {tri_in.b_x[15], tri_in.b_x} - {tri_in.a_x[15], tri_in.a_x};
            uy_reg <= {tri_in.b_y[15], tri_in.b_y} - {tri_in.a_y[15], tri_in.a_y};
            uz_reg <= {tri_in.b_z[15], tri_in.b_z} - {tri_in.a_z[15], tri_in.a_z};
            vx_reg <= {tri_in.c_x[15], tri_in.c_x} - {tri_in.a_x[15], tri_in.a_x};
            vy_reg <= {tri_in.c_y[15], tri_in.c_y} - {tri_in.a_y[15], tri_in.a_y};
            vz_reg <= {tri_in.c_z[15], tri_in.c_z} - {tri_in.a_z[15], tri_in.a_z};
        end
    end

    // Stage 1: the six cross-product terms.
    logic signed [tfn_pkg::PROD_W-1:0] prod_reg [6];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            prod_reg[0] <= uy_reg * vz_reg;
            prod_reg[1] <= uz_reg * vy_reg;
            prod_reg[2] <= uz_reg * vx_reg;
            prod_reg[3] <= ux_reg * vz_reg;
            prod_reg[4] <= ux_reg * vy_reg;
            prod_reg[5] <= uy_reg * vx_reg;
        end
    end

    // Stage 2: cross product w, exact.
    logic [tfn_pkg::CROSS_W-1:0] w_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int c = 0; c < 3; c++)
            begin
                w_reg[c] <= {prod_reg[2*c][tfn_pkg::PROD_W-1], prod_reg[2*c]}
                          - {prod_reg[2*c+1][tfn_pkg::PROD_W-1], prod_reg[2*c+1]};
            end
        end
    end

    // Stage 3: square each magnitude, keep the signs.
    logic [tfn_pkg::CROSS_W-1:0] wabs [3];
    logic [tfn_pkg::SQ_W-1:0]    sq_reg [3];
    logic [2:0]                  neg3_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            wabs[c] = w_reg[c][tfn_pkg::CROSS_W-1] ? (tfn_pkg::CROSS_W'(0) - w_reg[c])
                                                   : w_reg[c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int c = 0; c < 3; c++)
            begin
                sq_reg[c]   <= wabs[c][tfn_pkg::MAG_W-1:0] * wabs[c][tfn_pkg::MAG_W-1:0];
                neg3_reg[c] <= w_reg[c][tfn_pkg::CROSS_W-1];
            end
        end
    end

    // Stage 4: squared length, zero test.
    logic [tfn_pkg::SQ_W+1:0]  len_sum;
    logic [tfn_pkg::SQ_W-1:0]  l2_reg;
    logic [tfn_pkg::SQ_W-1:0]  w2_reg [3];
    tfn_pkg::tfn_side_t        side4_reg;

    assign len_sum = {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            l2_reg         <= len_sum[tfn_pkg::SQ_W-1:0];
            w2_reg         <= sq_reg;
            side4_reg.neg  <= neg3_reg;
            side4_reg.zero <= (len_sum == '0);
        end
    end

    // Stages 5 .. 51: one lane per component, side band travels alongside.
    logic [tfn_pkg::ROOT_W-1:0] root [3];
    tfn_pkg::tfn_side_t         side_reg [LS];

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_lane
            tfn_norm_lane u_lane
            (
                .clk  (clk),
                .en   (en[FS + LS - 1:FS]),
                .w2   (w2_reg[g]),
                .l2   (l2_reg),
                .root (root[g])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en[FS])
        begin
            side_reg[0] <= side4_reg;
        end
        for (int k = 1; k < LS; k++)
        begin
            if (en[FS + k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Output stage: r = (root + 1) / 2 rounds to nearest, then apply sign;
    // drop to zero for a degenerate triangle.
    logic [tfn_pkg::ROOT_W:0]        half_sum [3];
    logic [tfn_pkg::NORM_W-1:0]      mag_n    [3];
    logic [tfn_pkg::NORM_W-1:0]      out_next [3];
    logic [tfn_pkg::NORM_W-1:0]      nrm_reg  [3];
    logic                            nvalid_reg;
    tfn_pkg::tfn_side_t              side_last;

    assign side_last = side_reg[LS-1];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            half_sum[c] = {1'b0, root[c]} + 1'b1;
            mag_n[c]    = half_sum[c][tfn_pkg::ROOT_W:1];
            if (side_last.zero)
            begin
                out_next[c] = '0;
            end
            else if (side_last.neg[c])
            begin
                out_next[c] = tfn_pkg::NORM_W'(0) - mag_n[c];
            end
            else
            begin
                out_next[c] = mag_n[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            nrm_reg    <= out_next;
            nvalid_reg <= !side_last.zero;
        end
    end

    assign nrm_out.valid        = v_reg[NS-1];
    assign nrm_out.normal_x     = nrm_reg[0];
    assign nrm_out.normal_y     = nrm_reg[1];
    assign nrm_out.normal_z     = nrm_reg[2];
    assign nrm_out.normal_valid = nvalid_reg;

endmodule

FILE: tb/tb_triangle_face_normal.sv
// Testbench for triangle_face_normal: drives triangles through tfn_tri_if and
// checks every normal against a built-in exact predictor of the unit normal.
// Depends on tfn_pkg, tfn_if and the block itself.
module tb_triangle_face_normal;

    typedef struct packed {
        logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    } tri_t;

    typedef struct packed {
        logic signed [15:0] nx, ny, nz;
        logic               nv;
    } norm_t;

    // One directed row: the triangle plus, where obvious, its normal.
    typedef struct packed {
        tri_t  t;
        logic  known;
        norm_t n;
    } row_t;

    localparam int N_RANDOM  = 1500;
    localparam int DRAIN_CYC = 120;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tfn_tri_if  tri_ch();
    tfn_norm_if nrm_ch();

    triangle_face_normal DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .tri_in  (tri_ch.sink),
        .nrm_out (nrm_ch.source)
    );

    always #1 clk = ~clk;

    norm_t pending_normals[$];
    int    n_errors = 0;
    bit    gaps_on = 1'b1;
    bit    sending_done = 1'b0;

    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR @%0t: %s got %0d expected %0d", $time, what, got, want);
        n_errors++;
    endtask

    // Magnitude of one component: largest r in 0..16384 with
    // (2r-1)^2 * len2 <= w^2 * 2^30, found by binary search.
    function automatic logic [15:0] unit_mag(input logic [33:0] m, input logic [67:0] len2);
        logic [127:0] target;
        logic [127:0] lhs;
        int lo;
        int hi;
        int mid;
        longint odd;
        target = ({60'd0, m} * {60'd0, m}) << 30;
        lo = 0;
        hi = 16384;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            odd = 2 * mid - 1;
            lhs = {60'd0, len2} * 128'(odd * odd);
            if (lhs <= target)
                lo = mid;
            else
                hi = mid - 1;
        end
        return 16'(lo);
    endfunction

    function automatic norm_t face_normal(input tri_t t);
        logic signed [16:0] ux, uy, uz, vx, vy, vz;
        logic signed [34:0] w[3];
        logic [33:0]        m[3];
        logic [67:0]        len2;
        logic [15:0]        r;
        norm_t              n;
        ux = 17'(t.bx) - 17'(t.ax);
        uy = 17'(t.by) - 17'(t.ay);
        uz = 17'(t.bz) - 17'(t.az);
        vx = 17'(t.cx) - 17'(t.ax);
        vy = 17'(t.cy) - 17'(t.ay);
        vz = 17'(t.cz) - 17'(t.az);
        w[0] = 35'(uy) * 35'(vz) - 35'(uz) * 35'(vy);
        w[1] = 35'(uz) * 35'(vx) - 35'(ux) * 35'(vz);
        w[2] = 35'(ux) * 35'(vy) - 35'(uy) * 35'(vx);
        len2 = '0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = w[i] < 0 ? 34'(-w[i]) : 34'(w[i]);
            len2 += {34'd0, m[i]} * {34'd0, m[i]};
        end
        n = '0;
        if (len2 == 0)
            return n;
        n.nv = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            r = unit_mag(m[i], len2);
            if (w[i] < 0)
                r = -r;
            case (i)
                0: n.nx = r;
                1: n.ny = r;
                default: n.nz = r;
            endcase
        end
        return n;
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic tri_t rand_tri();
        tri_t t;
        t.ax = rand_coord(); t.ay = rand_coord(); t.az = rand_coord();
        t.bx = rand_coord(); t.by = rand_coord(); t.bz = rand_coord();
        t.cx = rand_coord(); t.cy = rand_coord(); t.cz = rand_coord();
        // Make some degenerate: coincident vertex, or collinear c unless c wraps.
        case ($urandom_range(0, 9))
            0: {t.cx, t.cy, t.cz} = {t.ax, t.ay, t.az};
            1: {t.cx, t.cy, t.cz} = {t.bx, t.by, t.bz};
            2:
            begin
                t.cx = t.ax + 2 * (t.bx - t.ax);
                t.cy = t.ay + 2 * (t.by - t.ay);
                t.cz = t.az + 2 * (t.bz - t.az);
            end
            default: ;
        endcase
        return t;
    endfunction

    // Hold the triangle until accepted; valid drops only for a random gap before it.
    task automatic send_tri(input tri_t t);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            tri_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        tri_ch.valid <= 1'b1;
        {tri_ch.a_x, tri_ch.a_y, tri_ch.a_z, tri_ch.b_x, tri_ch.b_y, tri_ch.b_z,
         tri_ch.c_x, tri_ch.c_y, tri_ch.c_z} <= t;
        do
            @(posedge clk);
        while (!tri_ch.ready);
        pending_normals = {pending_normals, face_normal(t)};
        @(negedge clk);
    endtask

    // Sink: random stall bursts, compare each taken normal with the oldest.
    initial
    begin
        int stall;
        norm_t want;
        stall = 0;
        nrm_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && nrm_ch.valid && nrm_ch.ready)
            begin
                if (pending_normals.size() == 0)
                    report_mismatch("unexpected normal, queue size", 0, 0);
                else
                begin
                    want = pending_normals.pop_front();
                    if (nrm_ch.normal_x !== want.nx)
                        report_mismatch("normal_x", nrm_ch.normal_x, want.nx);
                    if (nrm_ch.normal_y !== want.ny)
                        report_mismatch("normal_y", nrm_ch.normal_y, want.ny);
                    if (nrm_ch.normal_z !== want.nz)
                        report_mismatch("normal_z", nrm_ch.normal_z, want.nz);
                    if (nrm_ch.normal_valid !== want.nv)
                        report_mismatch("normal_valid", nrm_ch.normal_valid, want.nv);
                end
            end
            @(negedge clk);
            if (stall > 0)
                stall--;
            else if (gaps_on && $urandom_range(0, 7) == 0)
                stall = $urandom_range(1, 7);
            nrm_ch.ready <= (stall == 0);
        end
    end

    initial
    begin
        row_t rows[$];
        row_t r;
        tri_t t;
        int   wait_cyc;
        tri_ch.valid = 1'b0;
        {tri_ch.a_x, tri_ch.a_y, tri_ch.a_z, tri_ch.b_x, tri_ch.b_y, tri_ch.b_z,
         tri_ch.c_x, tri_ch.c_y, tri_ch.c_z} = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: all-zero and coincident triangles are degenerate;
        // axis-aligned right triangles give exact unit normals.
        r = '0; r.known = 1'b1; rows = {rows, r};
        r.t = {9{16'h7fff}}; rows = {rows, r};
        r.t = {9{16'h8000}}; rows = {rows, r};
        r = '0; r.known = 1'b1;
        r.t.bx = 16'h0100; r.t.cy = 16'h0100;
        r.n = '{nx: 16'sd0, ny: 16'sd0, nz: 16'sd16384, nv: 1'b1}; rows = {rows, r};
        r.t.bx = 16'h0000; r.t.by = 16'h0100; r.t.cy = 16'h0000; r.t.cx = 16'h0100;
        r.n = '{nx: 16'sd0, ny: 16'sd0, nz: -16'sd16384, nv: 1'b1}; rows = {rows, r};
        r = '0; r.known = 1'b1;
        r.t.by = 16'h0001; r.t.cz = 16'h0001;
        r.n = '{nx: 16'sd16384, ny: 16'sd0, nz: 16'sd0, nv: 1'b1}; rows = {rows, r};
        r = '0; r.known = 1'b1;
        r.t.bz = 16'h0001; r.t.cx = 16'h0001;
        r.n = '{nx: 16'sd0, ny: 16'sd16384, nz: 16'sd0, nv: 1'b1}; rows = {rows, r};
        // Collinear along a diagonal: degenerate.
        r = '0; r.known = 1'b1;
        r.t.bx = 16'h0010; r.t.by = 16'h0010; r.t.bz = 16'h0010;
        r.t.cx = 16'h0020; r.t.cy = 16'h0020; r.t.cz = 16'h0020; rows = {rows, r};
        // Largest edges and sign-bit corners, checked by the predictor.
        r = '0;
        r.t = {16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
               16'h8000, 16'h7fff, 16'h8000}; rows = {rows, r};
        r.t = {16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
               16'h8000, 16'h8000, 16'h7fff}; rows = {rows, r};
        r.t = {16'h8000, 16'h7fff, 16'h0000, 16'h7fff, 16'h8000, 16'h7fff,
               16'h0001, 16'hffff, 16'h8000}; rows = {rows, r};
        r.t = {16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0000,
               16'h0001, 16'h0000, 16'h0001}; rows = {rows, r};
        r.t = {16'hffff, 16'h5555, 16'haaaa, 16'h1234, 16'hedcb, 16'h0f0f,
               16'hf0f0, 16'h00ff, 16'hff00}; rows = {rows, r};

        foreach (rows[i])
        begin
            send_tri(rows[i].t);
            if (rows[i].known && pending_normals[$] !== rows[i].n)
                report_mismatch("directed row predictor", i, 0);
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            // Hold off once until the pipe is empty.
            if (i == N_RANDOM / 2)
            begin
                tri_ch.valid <= 1'b0;
                do
                    @(negedge clk);
                while (pending_normals.size() != 0);
            end
            if (i == N_RANDOM - 200)
                gaps_on = 1'b0;
            t = rand_tri();
            send_tri(t);
        end
        tri_ch.valid <= 1'b0;

        wait_cyc = 0;
        while (pending_normals.size() != 0 && wait_cyc < 100000)
        begin
            @(negedge clk);
            wait_cyc++;
        end
        repeat (DRAIN_CYC) @(negedge clk);
        if (n_errors == 0 && pending_normals.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
